[hdl/assert_macros.svh]
// assert_macros.svh: concurrent assertion macros for the block
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/stlo_pkg.sv]
// stlo_pkg: shared types, constants and tree index functions
// used by the level-order core; no dependencies
`timescale 1ns / 1ps
package stlo_pkg;

  localparam int SYM_W = 8;
  // heap indices and ranks for up to 64 nodes
  localparam int IDX_W = 7;
  // in-order position in the perfect tree, below 128
  localparam int POS_W = 8;

  typedef logic [SYM_W-1:0] sym_t;

  typedef struct packed {
    sym_t symbol;
    logic last;
    logic overflow;
  } out_item_t;

  // floor log2, zero for zero
  function automatic logic [2:0] flog2(logic [IDX_W-1:0] v);
    logic [2:0] r;
    r = '0;
    for (int i = 0; i < IDX_W; i++) begin
      if (v[i]) r = 3'(i);
    end
    return r;
  endfunction

  // in-order rank of heap node h in a complete tree of depth dn,
  // m2 being twice the node count of the bottom level
  function automatic logic [IDX_W-1:0] heap_rank(logic [IDX_W-1:0] h, logic [2:0] dn,
                                                 logic [POS_W-1:0] m2);
    logic [2:0]       d;
    logic [IDX_W-1:0] off;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] excess;
    logic [POS_W-1:0] r;
    d      = flog2(h);
    off    = h - (IDX_W'(1) << d);
    p      = ({off, 1'b1} << (dn - d)) - POS_W'(1);
    excess = p - m2;
    // bottom slots missing to the right shift the rank down
    if (p > m2) r = p - ((excess + POS_W'(1)) >> 1);
    else r = p;
    return IDX_W'(r);
  endfunction

endpackage

[hdl/stlo_ram.sv]
// stlo_ram: generic single-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module stlo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[hdl/sorted_to_level_order_core.sv]
// sorted_to_level_order_core: reorders a sorted run into complete-bst level order
// depends on stlo_pkg, stlo_ram and assert_macros.svh
//
// usage
//   input channel (symbol, last; in_valid / in_stall): one item per cycle while
//   loading. each symbol is written to the symbol ram; an item with last set
//   ends the run. symbols beyond MAX_SYMBOLS are dropped and the run flagged.
//   output channel (symbol_out, last_out, overflow; out_valid / out_stall):
//   after the last item the run is emitted in breadth-first tree order, one item
//   per cycle while out_stall is low, last_out on the final one, overflow on all.
//   emit path: after the last item is accepted, the first result passes the
//   emit sequencer, the registered ram read and the output queue; n results
//   then follow one per cycle while out_stall is low. loading and emitting do
//   not overlap: in_stall stays high until the final read of the run is issued,
//   and the single read port of the symbol ram sets the emit rate.
//   the ram read address comes straight from the heap index through a closed
//   form rank computation, so there is no tree walk.
//   stall: reads are issued only while the two-entry output queue has room,
//   so out_stall simply pauses the emit sequence without losing items.
//   reset: count, overflow flag, emit sequencer and output queue clear; the
//   ram holds no reset value and is only read where the run has written.
`timescale 1ns / 1ps
module sorted_to_level_order_core #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  stlo_pkg::sym_t     symbol,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output stlo_pkg::sym_t     symbol_out,
  output logic               last_out,
  output logic               overflow
);
  import stlo_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  // sequencer codes
  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic             state, state_next;
  logic [CW-1:0]    count, count_next;   // symbols stored in this run
  logic             ovf_seen, ovf_seen_next;
  logic [CW-1:0]    run_n;               // node count of the run being emitted
  logic [2:0]       run_depth;           // depth of its bottom level
  logic [POS_W-1:0] run_m2;              // twice the bottom level node count
  logic             run_ovf;
  logic [CW-1:0]    heap_idx;            // next heap node to read, from 1

  // input side
  logic          in_accept;
  logic          room;
  logic [CW-1:0] n_fin;
  logic [2:0]    d_fin;

  assign in_stall  = (state != ST_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign room      = (count < CW'(MAX_SYMBOLS));
  // run length once this item is taken in
  assign n_fin     = room ? (count + CW'(1)) : count;
  assign d_fin     = flog2(IDX_W'(n_fin));

  // emit side: ram read issue and output queue credit
  logic       issue;
  logic       issue_last;
  logic       inflight;           // ram read data valid on rd_data
  logic       rd_last, rd_ovf;
  logic [1:0] q_cnt;
  logic       q_pop;
  logic [2:0] q_used;
  logic [IDX_W-1:0] rank_full;
  logic [AW-1:0]    rd_addr;
  sym_t             rd_data;

  assign q_pop      = out_valid && !out_stall;
  // queue slots taken after this cycle if nothing new is issued
  assign q_used     = 3'(q_cnt) + 3'(inflight) - 3'(q_pop);
  assign issue      = (state == ST_EMIT) && (q_used < 3'd2);
  assign issue_last = (heap_idx == run_n);
  assign rank_full  = heap_rank(IDX_W'(heap_idx), run_depth, run_m2);
  assign rd_addr    = rank_full[AW-1:0];

  stlo_ram #(
    .WIDTH (SYM_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_store (
    .clk   (clk),
    .we    (in_accept && room),
    .waddr (count[AW-1:0]),
    .wdata (symbol),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next    = state;
    count_next    = count;
    ovf_seen_next = ovf_seen;
    case (state)
      ST_LOAD: begin
        if (in_accept) begin
          if (room) count_next = count + CW'(1);
          else ovf_seen_next = 1'b1;
          if (last) state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // run finished once the final read is issued
        if (issue && issue_last) begin
          state_next    = ST_LOAD;
          count_next    = '0;
          ovf_seen_next = 1'b0;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      ovf_seen <= 1'b0;
      inflight <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      ovf_seen <= ovf_seen_next;
      inflight <= issue;
    end
  end

  // run shape latched at the end of the load; heap index advanced on each read issue
  always_ff @(posedge clk) begin
    if (in_accept && last) begin
      run_n     <= n_fin;
      run_depth <= d_fin;
      run_m2    <= (POS_W'(n_fin) - (POS_W'(1) << d_fin) + POS_W'(1)) << 1;
      run_ovf   <= ovf_seen || !room;
      heap_idx  <= CW'(1);
    end else if (issue) begin
      heap_idx  <= heap_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last <= issue_last;
      rd_ovf  <= run_ovf;
    end
  end

  // two-entry output queue
  out_item_t q_mem [2];
  logic      q_wr, q_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
      q_wr  <= 1'b0;
      q_rd  <= 1'b0;
    end else begin
      q_cnt <= 2'(3'(q_cnt) + 3'(inflight) - 3'(q_pop));
      if (inflight) q_wr <= !q_wr;
      if (q_pop) q_rd <= !q_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (inflight) q_mem[q_wr] <= '{symbol: rd_data, last: rd_last, overflow: rd_ovf};
  end

  assign out_valid  = (q_cnt != 2'd0);
  assign symbol_out = q_mem[q_rd].symbol;
  assign last_out   = q_mem[q_rd].last;
  assign overflow   = q_mem[q_rd].overflow;

  `ASSERT_ALWAYS(a_queue_credit, clk, rst, (3'(q_cnt) + 3'(inflight)) <= 3'd2)
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CW'(MAX_SYMBOLS))
  `ASSERT_ALWAYS(a_idx_in_run, clk, rst, (state != ST_EMIT) || (heap_idx <= run_n))
  `ASSERT_NEXT(a_run_end, clk, rst, issue && issue_last,
               (state == ST_LOAD) && (count == '0) && !ovf_seen)

endmodule
